// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// The consequent must hold in the cycle after reset is seen high.
`define ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("assertion failed: after-reset check");

`endif

// ===== design/els_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator LOOK scheduler package
// Status codes, controller states and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package els_pkg;

  // Result codes reported with every item.
  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_CANCELLED = 3'd1,
    ST_RANGE     = 3'd2,
    ST_EXITED    = 3'd3,
    ST_ARRIVED   = 3'd4,
    ST_NONE      = 3'd5,
    ST_HALTED    = 3'd6
  } status_t;

  // Command field values.
  localparam logic CMD_PRESS = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;

  // Reset value of the top floor register.
  localparam logic [7:0] TOP_FLOOR_RESET = 8'd80;

  // Width used for floor comparisons; holds the top floor plus one.
  localparam int CMP_W = 9;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_PRESS_WR,
    S_SCAN1,
    S_SCAN2,
    S_MOVE,
    S_DONE
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_wr;
    logic    load_item;
    logic    press_rd;
    logic    press_wr;
    logic    scan_start;
    logic    scan_dir_up;
    logic    scan_run;
    logic    set_dir;
    logic    dir_val;
    logic    set_session;
    logic    move;
    logic    out_load;
    status_t out_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic halted;
    logic is_close;
    logic range_err;
    logic at_car;
    logic rd_bit;
    logic scan_hit;
    logic scan_miss;
    logic going_up;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== design/els_ifs.sv =====
// ----------------------------------------------------------------------------
// Elevator LOOK scheduler channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------

// Command channel: one press or close-doors item.
interface els_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] floor;

  modport source (output valid, output cmd, output floor, input ready);
  modport sink   (input valid, input cmd, input floor, output ready);
endinterface

// Result channel: one result item per command item.
interface els_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] current_floor;
  logic       heading_up;

  modport source (output valid, output status, output current_floor,
                  output heading_up, input ready);
  modport sink   (input valid, input status, input current_floor,
                  input heading_up, output ready);
endinterface

// ===== design/els_ctrl.sv =====
// ----------------------------------------------------------------------------
// Elevator LOOK scheduler controller
// Sequences the clearing pass, press handling, the two-direction floor scan
// and the result hand-off.
// ----------------------------------------------------------------------------
module els_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  els_pkg::dp_sts_t sts,
  output els_pkg::dp_cmd_t cmd
);
  import els_pkg::*;

  ctl_state_t state, state_next;
  status_t    res_code, res_code_next;

  // State and result code registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      res_code <= ST_ADDED;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.out_status = res_code;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.halted) begin
          res_code_next = ST_HALTED;
          state_next    = S_DONE;
        end else if (!sts.is_close) begin
          if (sts.range_err) begin
            res_code_next = ST_RANGE;
            state_next    = S_DONE;
          end else if (sts.at_car) begin
            cmd.set_session = 1'b1;
            res_code_next   = ST_EXITED;
            state_next      = S_DONE;
          end else begin
            cmd.press_rd = 1'b1;
            state_next   = S_PRESS_WR;
          end
        end else begin
          cmd.scan_start  = 1'b1;
          cmd.scan_dir_up = sts.going_up;
          state_next      = S_SCAN1;
        end
      end
      S_PRESS_WR: begin
        // The request bit read last cycle is toggled.
        cmd.press_wr  = 1'b1;
        res_code_next = sts.rd_bit ? ST_CANCELLED : ST_ADDED;
        state_next    = S_DONE;
      end
      S_SCAN1: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_hit) begin
          state_next = S_MOVE;
        end else if (sts.scan_miss) begin
          cmd.scan_start  = 1'b1;
          cmd.scan_dir_up = !sts.going_up;
          state_next      = S_SCAN2;
        end
      end
      S_SCAN2: begin
        // The second scan runs against the stored direction, which flips
        // only when this scan finds a floor or the first scan was upward.
        cmd.scan_run = 1'b1;
        if (sts.scan_hit) begin
          cmd.set_dir = 1'b1;
          cmd.dir_val = !sts.going_up;
          state_next  = S_MOVE;
        end else if (sts.scan_miss) begin
          cmd.set_dir   = 1'b1;
          cmd.dir_val   = 1'b0;
          res_code_next = ST_NONE;
          state_next    = S_DONE;
        end
      end
      S_MOVE: begin
        cmd.move      = 1'b1;
        res_code_next = ST_ARRIVED;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/els_dpath.sv =====
// ----------------------------------------------------------------------------
// Elevator LOOK scheduler datapath
// Request bitmap memory, car state, serial floor scanner and result register.
// ----------------------------------------------------------------------------
module els_dpath #(
  parameter int MAX_FLOORS = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  logic             in_cmd,
  input  logic [7:0]       in_floor,
  input  els_pkg::dp_cmd_t cmd,
  output els_pkg::dp_sts_t sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_floor,
  output logic             out_heading
);
  import els_pkg::*;

  localparam int AW    = $clog2(MAX_FLOORS + 1);
  localparam int PW    = $clog2(MAX_FLOORS + 2);
  localparam int DEPTH = MAX_FLOORS + 1;

  logic [7:0]       top_floor;
  logic [AW-1:0]    car;
  logic             going_up;
  logic             session_over;
  logic             item_close;
  logic [7:0]       item_floor;
  logic [AW-1:0]    clr_ptr;
  logic [PW-1:0]    scan_ptr;
  logic             scan_up;
  logic [AW-1:0]    rd_ptr;
  logic             rd_pend;
  logic             mem_rdata;
  logic             mem [DEPTH];

  logic [AW-1:0]    top_use;
  logic [CMP_W-1:0] top_ext;
  logic [CMP_W-1:0] top_plus1;
  logic [CMP_W-1:0] car_ext;
  logic [CMP_W-1:0] floor_ext;
  logic [CMP_W-1:0] ptr_ext;
  logic [CMP_W-1:0] down_start;
  logic             issue_ok;
  logic             issue;
  logic             scan_hit;
  logic             scan_miss;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             wr_data;

  // Top floor in use is capped at the building size.
  always_comb begin
    if (CMP_W'(top_floor) > CMP_W'(MAX_FLOORS)) begin
      top_use = AW'(MAX_FLOORS);
    end else begin
      top_use = AW'(top_floor);
    end
    top_ext    = CMP_W'(top_use);
    top_plus1  = top_ext + CMP_W'(1);
    car_ext    = CMP_W'(car);
    floor_ext  = CMP_W'(item_floor);
    ptr_ext    = CMP_W'(scan_ptr);
    down_start = (car_ext > top_plus1) ? top_plus1 : car_ext;
  end

  // Scan control: one address issued per cycle, its result checked in the next cycle.
  assign issue_ok  = scan_up ? (ptr_ext <= top_ext) : (ptr_ext != '0);
  assign scan_hit  = rd_pend & mem_rdata;
  assign scan_miss = !rd_pend & !issue_ok;
  assign issue     = cmd.scan_run & issue_ok & !scan_hit;

  // Memory port selection.
  always_comb begin
    rd_en   = cmd.press_rd | issue;
    rd_addr = cmd.press_rd ? item_floor[AW-1:0] : scan_ptr[AW-1:0];
    wr_en   = cmd.clr_wr | cmd.press_wr | cmd.move;
    wr_addr = clr_ptr;
    wr_data = 1'b0;
    if (cmd.press_wr) begin
      wr_addr = item_floor[AW-1:0];
      wr_data = !mem_rdata;
    end else if (cmd.move) begin
      wr_addr = rd_ptr;
    end
  end

  // Request bitmap memory, one bit per floor.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rdata <= mem[rd_addr];
    end
  end

  // Control and car state.
  always_ff @(posedge clk) begin
    if (rst) begin
      top_floor    <= TOP_FLOOR_RESET;
      car          <= AW'(1);
      going_up     <= 1'b1;
      session_over <= 1'b0;
      clr_ptr      <= '0;
      rd_pend      <= 1'b0;
      scan_up      <= 1'b1;
      scan_ptr     <= '0;
    end else begin
      if (cfg_wr_en) begin
        top_floor <= cfg_wr_data;
      end
      if (cmd.clr_wr && clr_ptr != AW'(MAX_FLOORS)) begin
        clr_ptr <= clr_ptr + AW'(1);
      end
      if (cmd.set_session) begin
        session_over <= 1'b1;
      end
      if (cmd.set_dir) begin
        going_up <= cmd.dir_val;
      end
      if (cmd.move) begin
        car <= rd_ptr;
      end
      if (cmd.scan_start) begin
        scan_up <= cmd.scan_dir_up;
        rd_pend <= 1'b0;
        if (cmd.scan_dir_up) begin
          scan_ptr <= PW'(car_ext + CMP_W'(1));
        end else begin
          scan_ptr <= PW'(down_start - CMP_W'(1));
        end
      end else begin
        rd_pend <= issue;
        if (issue) begin
          scan_ptr <= scan_up ? scan_ptr + PW'(1) : scan_ptr - PW'(1);
        end
      end
    end
  end

  // Item capture and address of the last issued scan read.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_close <= in_cmd;
      item_floor <= in_floor;
    end
    if (issue) begin
      rd_ptr <= scan_ptr[AW-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status  <= cmd.out_status;
      out_floor   <= 8'(car);
      out_heading <= going_up;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.clr_done  = (clr_ptr == AW'(MAX_FLOORS));
    sts.halted    = session_over;
    sts.is_close  = (item_close == CMD_CLOSE);
    sts.range_err = (item_floor == 8'd0) || (floor_ext > top_ext);
    sts.at_car    = (floor_ext == car_ext);
    sts.rd_bit    = mem_rdata;
    sts.scan_hit  = scan_hit;
    sts.scan_miss = scan_miss;
    sts.going_up  = going_up;
    sts.out_free  = !out_valid | out_ready;
  end

endmodule

// ===== design/elevator_look_scheduler.sv =====
// After reset the block clears its request bitmap, one floor a cycle, and
// accepts no item until that is done; the top floor register may be written
// at any time while idle. A press item that is out of range, exits or finds
// the session halted is settled in decode and goes on to the result load;
// one that toggles a request goes through decode with the bitmap read, the
// toggle write, then the result load. A close-doors item walks the bitmap
// one floor per cycle through a single-port memory, first in the current
// direction and then, if nothing is found, in the other. One item is worked
// at a time; a finished result waits in an output register while the next
// item is taken.
// ----------------------------------------------------------------------------
// Elevator LOOK scheduler
// Toggles floor requests on button presses and, on close doors, moves the car
// to the nearest requested floor in the travel direction, reversing if none.
// ----------------------------------------------------------------------------
module elevator_look_scheduler #(
  parameter int MAX_FLOORS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  els_req_if.sink     req,
  els_rsp_if.source   rsp
);
  import els_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_sts_t    dp_sts;
  logic       ctl_ready;
  logic       out_valid;
  logic [2:0] out_status;
  logic [7:0] out_floor;
  logic       out_heading;

  // Controller.
  els_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ctl_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // Datapath.
  els_dpath #(
    .MAX_FLOORS (MAX_FLOORS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (req.cmd),
    .in_floor    (req.floor),
    .cmd         (dp_cmd),
    .sts         (dp_sts),
    .out_valid   (out_valid),
    .out_ready   (rsp.ready),
    .out_status  (out_status),
    .out_floor   (out_floor),
    .out_heading (out_heading)
  );

  // Channel hookup.
  assign req.ready         = ctl_ready;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.current_floor = out_floor;
  assign rsp.heading_up    = out_heading;

endmodule

// ===== design/els_checker.sv =====
// ----------------------------------------------------------------------------
// Elevator LOOK scheduler checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module els_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] rsp_status,
  input logic [7:0] rsp_current_floor,
  input logic       rsp_heading_up
);
  import els_pkg::*;

  // A stalled result stays offered.
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  // A stalled result keeps its fields.
  `ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_current_floor) && $stable(rsp_heading_up))

  // With nothing requested the car always ends up heading down.
  `ASSERT_NOW(a_none_down, clk, rst, rsp_valid && rsp_status == ST_NONE, !rsp_heading_up)

  // The car is never reported at floor zero.
  `ASSERT_NOW(a_floor_nonzero, clk, rst, rsp_valid, rsp_current_floor != 8'd0)

  // No result is offered right after reset.
  `ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !rsp_valid)

endmodule

bind elevator_look_scheduler els_checker u_els_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_current_floor (rsp.current_floor),
  .rsp_heading_up    (rsp.heading_up)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Elevator LOOK scheduler testbench
// Drives press and close-doors items through the command channel, predicts
// every result item with a cycle-free model of the request bitmap, the car
// floor and the travel direction, and checks each result field by field.
// A directed table comes first, followed by random phases over many top floor
// settings, and finally the exit press and the halted session.
// ----------------------------------------------------------------------------
module tb_top;
  import els_pkg::*;

  localparam int MAX_FLOORS  = 128;
  localparam int N_RANDOM    = 1370;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 2 * MAX_FLOORS + 16;

  // One result item as the car reports it.
  typedef struct packed {
    status_t    status;
    logic [7:0] floor;
    logic       heading_up;
  } car_report_t;

  // One row of the directed table.
  typedef struct {
    bit          set_top;
    logic [7:0]  top;
    logic        cmd;
    logic [7:0]  floor;
    bit          typed;
    car_report_t res;
  } step_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  els_req_if req_ch();
  els_rsp_if rsp_ch();

  elevator_look_scheduler #(
    .MAX_FLOORS (MAX_FLOORS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Predicted state of the scheduler.
  bit [MAX_FLOORS:0] floor_calls;
  int                car_pos;
  bit                moving_up;
  bit                exited;
  int                top_cfg;

  car_report_t expected_reports[$];
  step_row_t   dir_rows[$];
  bit          given_typed;
  car_report_t given_res;
  int          idle_pct = 33;
  int          n_err = 0;
  int          quiet_cycles = 0;

  function automatic int top_in_use();
    return (top_cfg > MAX_FLOORS) ? MAX_FLOORS : top_cfg;
  endfunction

  // Nearest requested floor strictly above the car, 0 if there is none.
  function automatic int find_above(input int tu);
    for (int f = car_pos + 1; f <= tu; f++) begin
      if (floor_calls[f]) return f;
    end
    return 0;
  endfunction

  // Nearest requested floor strictly below the car, 0 if there is none.
  // A car above the top floor starts its downward search at the top floor.
  function automatic int find_below(input int tu);
    int f;
    f = car_pos;
    if (f > tu + 1) f = tu + 1;
    while (f > 1) begin
      f--;
      if (floor_calls[f]) return f;
    end
    return 0;
  endfunction

  // Applies one command to the predicted state and returns its report.
  function automatic car_report_t look_step(input logic cmd, input logic [7:0] fl);
    car_report_t r;
    int          tu;
    int          tgt;
    tu  = top_in_use();
    tgt = 0;
    if (exited) begin
      r.status = ST_HALTED;
    end else if (cmd == CMD_PRESS) begin
      if (fl < 1 || fl > tu) begin
        r.status = ST_RANGE;
      end else if (fl == car_pos) begin
        exited   = 1'b1;
        r.status = ST_EXITED;
      end else if (floor_calls[fl]) begin
        floor_calls[fl] = 1'b0;
        r.status        = ST_CANCELLED;
      end else begin
        floor_calls[fl] = 1'b1;
        r.status        = ST_ADDED;
      end
    end else begin
      // LOOK: keep the direction while something lies ahead, else reverse.
      if (moving_up) begin
        tgt = find_above(tu);
        if (tgt == 0) begin
          moving_up = 1'b0;
          tgt       = find_below(tu);
        end
      end else begin
        tgt = find_below(tu);
        if (tgt == 0) begin
          tgt       = find_above(tu);
          moving_up = (tgt != 0);
        end
      end
      if (tgt != 0) begin
        car_pos          = tgt;
        floor_calls[tgt] = 1'b0;
        r.status         = ST_ARRIVED;
      end else begin
        r.status = ST_NONE;
      end
    end
    r.floor      = car_pos[7:0];
    r.heading_up = moving_up;
    return r;
  endfunction

  function automatic void add_row(input bit set_top, input int top, input logic cmd,
                                  input int fl, input bit typed = 1'b0,
                                  input status_t st = ST_ADDED, input int cf = 0,
                                  input bit hu = 1'b0);
    step_row_t row;
    row.set_top = set_top;
    row.top     = top[7:0];
    row.cmd     = cmd;
    row.floor   = fl[7:0];
    row.typed   = typed;
    row.res     = '{st, cf[7:0], hu};
    dir_rows.push_back(row);
  endfunction

  // Presents one item, sometimes after a random gap, and returns at the falling
  // edge after it was accepted.
  task automatic send_item(input logic cmd, input logic [7:0] fl,
                           input bit typed = 1'b0, input car_report_t res = '0);
    if ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    given_typed = typed;
    given_res   = res;
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= cmd;
    req_ch.floor <= fl;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Writes the top floor once every outstanding result has come back.
  task automatic set_top_floor(input logic [7:0] v);
    req_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    top_cfg = v;
  endtask

  // Result ready toggles at random on the falling edge.
  always @(negedge clk) begin
    if (!rst) rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Every accepted command item queues its expected report.
  always @(posedge clk) begin : accept_mon
    car_report_t want;
    if (!rst && req_ch.valid && req_ch.ready) begin
      want = look_step(req_ch.cmd, req_ch.floor);
      if (given_typed) want = given_res;
      expected_reports.push_back(want);
    end
  end

  // Every accepted result item is compared with the oldest expectation.
  always @(posedge clk) begin : result_chk
    car_report_t got;
    car_report_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{status_t'(rsp_ch.status), rsp_ch.current_floor, rsp_ch.heading_up};
      if (expected_reports.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result item status=%0d floor=%0d up=%0d",
                 $time, got.status, got.floor, got.heading_up);
      end else begin
        want = expected_reports.pop_front();
        if (got.status !== want.status || got.floor !== want.floor ||
            got.heading_up !== want.heading_up) begin
          n_err++;
          $display("%0t: mismatch expected status=%0d floor=%0d up=%0d, actual status=%0d floor=%0d up=%0d",
                   $time, want.status, want.floor, want.heading_up,
                   got.status, got.floor, got.heading_up);
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int         ph;
    int         len;
    int         sent;
    int         tu;
    int         pick;
    logic       cmd;
    logic [7:0] fl;
    logic [7:0] top;

    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd   = CMD_PRESS;
    req_ch.floor = '0;
    rsp_ch.ready = 1'b0;
    given_typed  = 1'b0;
    given_res    = '0;
    floor_calls  = '0;
    car_pos      = 1;
    moving_up    = 1'b1;
    exited       = 1'b0;
    top_cfg      = TOP_FLOOR_RESET;

    // Directed table. Reset top floor first, then each extreme setting.
    add_row(0, 0, CMD_CLOSE, 0, 1, ST_NONE, 1, 0);
    add_row(0, 0, CMD_PRESS, 0, 1, ST_RANGE, 1, 0);
    add_row(0, 0, CMD_PRESS, 81, 1, ST_RANGE, 1, 0);
    add_row(0, 0, CMD_PRESS, 255, 1, ST_RANGE, 1, 0);
    add_row(0, 0, CMD_PRESS, 80, 1, ST_ADDED, 1, 0);
    add_row(0, 0, CMD_PRESS, 80, 1, ST_CANCELLED, 1, 0);
    add_row(0, 0, CMD_PRESS, 80, 1, ST_ADDED, 1, 0);
    add_row(0, 0, CMD_PRESS, 40);
    add_row(0, 0, CMD_PRESS, 60);
    add_row(0, 0, CMD_CLOSE, 255);
    add_row(0, 0, CMD_CLOSE, 0);
    add_row(0, 0, CMD_PRESS, 20);
    add_row(0, 0, CMD_CLOSE, 0);
    add_row(0, 0, CMD_CLOSE, 0);
    // Top floor above the floor limit is clipped to the limit.
    add_row(1, 255, CMD_PRESS, 129, 1, ST_RANGE, 20, 0);
    add_row(0, 0, CMD_PRESS, 128, 1, ST_ADDED, 20, 0);
    add_row(0, 0, CMD_CLOSE, 170);
    // Top floor of zero: every press is out of range.
    add_row(1, 0, CMD_PRESS, 1, 1, ST_RANGE, 128, 1);
    add_row(0, 0, CMD_PRESS, 128, 1, ST_RANGE, 128, 1);
    add_row(0, 0, CMD_CLOSE, 0, 1, ST_NONE, 128, 0);
    // Single floor building with the car far above it.
    add_row(1, 1, CMD_PRESS, 2, 1, ST_RANGE, 128, 0);
    add_row(0, 0, CMD_PRESS, 1, 1, ST_ADDED, 128, 0);
    add_row(0, 0, CMD_CLOSE, 0);
    // Full height, then the top floor is lowered below the car.
    add_row(1, 128, CMD_PRESS, 100);
    add_row(0, 0, CMD_PRESS, 127);
    add_row(0, 0, CMD_CLOSE, 0);
    add_row(1, 50, CMD_PRESS, 30);
    add_row(0, 0, CMD_CLOSE, 0);
    add_row(0, 0, CMD_PRESS, 127, 1, ST_RANGE, 30, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_top) set_top_floor(dir_rows[i].top);
      send_item(dir_rows[i].cmd, dir_rows[i].floor, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random phases. Each one drains the block, writes a new top floor and
    // sends mostly in-range presses mixed with close-doors items. Small
    // buildings dominate so that searches hit often in both directions.
    sent = 0;
    for (ph = 0; sent < N_RANDOM; ph++) begin
      case ($urandom_range(11))
        0:       top = 8'd0;
        1:       top = 8'd1;
        2:       top = 8'd128;
        3:       top = 8'($urandom_range(255, 129));
        4, 5:    top = 8'($urandom_range(255));
        default: top = 8'($urandom_range(16, 2));
      endcase
      set_top_floor(top);
      // One long phase runs with no idling on either side.
      idle_pct = (ph == 2) ? 0 : 33;
      len = (ph == 2) ? 200 : $urandom_range(120, 40);
      repeat (len) begin
        tu   = top_in_use();
        pick = $urandom_range(99);
        if (pick < 10) begin
          cmd = 1'($urandom_range(1));
          fl  = 8'($urandom_range(255));
        end else if (pick < 40) begin
          cmd = CMD_CLOSE;
          fl  = 8'($urandom_range(255));
        end else begin
          cmd = CMD_PRESS;
          fl  = (tu > 0) ? 8'($urandom_range(tu, 1)) : 8'd0;
        end
        // A press at the car floor would end the session, so it waits
        // for the very end.
        if (cmd == CMD_PRESS && fl == car_pos && fl <= tu) cmd = CMD_CLOSE;
        send_item(cmd, fl);
        sent++;
      end
    end
    idle_pct = 33;

    // Exit at the car floor, after which every item reports halted.
    set_top_floor(8'd255);
    send_item(CMD_PRESS, car_pos[7:0]);
    send_item(CMD_CLOSE, 8'd0);
    send_item(CMD_PRESS, 8'd0);
    send_item(CMD_PRESS, 8'd255);
    set_top_floor(8'd3);
    send_item(CMD_PRESS, 8'd2);

    req_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
